// ===== rtl/core/rict_pkg.sv =====
// Shared types and constants for the route id table.
`timescale 1ns / 1ps
package rict_pkg;
	localparam int TableDepthDef = 64;
	localparam int AddrW = 48;
	localparam int RidW = 32;
	localparam int ModeW = 2;
	localparam int StatW = 3;
	localparam int SlotW = 6;

	localparam logic [ModeW-1:0] MODE_BY_ID = 2'd0;
	localparam logic [ModeW-1:0] MODE_BY_DST = 2'd1;
	localparam logic [ModeW-1:0] MODE_INSERT = 2'd2;
	localparam logic [ModeW-1:0] MODE_UNUSED = 2'd3;

	localparam logic [StatW-1:0] ST_HIT = 3'd0;
	localparam logic [StatW-1:0] ST_MISS = 3'd1;
	localparam logic [StatW-1:0] ST_NEW = 3'd2;
	localparam logic [StatW-1:0] ST_UPD = 3'd3;
	localparam logic [StatW-1:0] ST_FULL = 3'd4;

	typedef struct packed {
		logic [ModeW-1:0] mode;
		logic [AddrW-1:0] src;
		logic [AddrW-1:0] dst;
		logic [AddrW-1:0] prev_hop;
		logic [AddrW-1:0] fwd_hop;
		logic [RidW-1:0] rid;
	} req_t;

	localparam int EntW = 4 * AddrW + RidW;
endpackage

// ===== rtl/core/route_id_cache_table_unit.sv =====
// Top level of the route id table: front queue plus scanning back end.
// A lookup scans occupied slots one per cycle through the table RAM read port;
// the back end takes a new request only when idle with its output register empty,
// while the two-entry front queue keeps accepting items.
// Reset (arst_n low, async) empties the table and the queue; entry data is not cleared.
`timescale 1ns / 1ps
module route_id_cache_table_unit #(
	parameter int TableDepth = rict_pkg::TableDepthDef
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [rict_pkg::ModeW-1:0]   mode,
	input  logic [rict_pkg::AddrW-1:0]   src_addr,
	input  logic [rict_pkg::AddrW-1:0]   dst_addr,
	input  logic [rict_pkg::AddrW-1:0]   prev_hop,
	input  logic [rict_pkg::AddrW-1:0]   fwd_hop,
	input  logic [rict_pkg::RidW-1:0]    route_id,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [rict_pkg::StatW-1:0]   status,
	output logic [rict_pkg::SlotW-1:0]   slot,
	output logic [rict_pkg::AddrW-1:0]   out_src,
	output logic [rict_pkg::AddrW-1:0]   out_dst,
	output logic [rict_pkg::AddrW-1:0]   out_prev_hop,
	output logic [rict_pkg::AddrW-1:0]   out_fwd_hop,
	output logic [rict_pkg::RidW-1:0]    out_route_id
);
	rict_pkg::req_t in_req, q_req;
	logic q_valid, q_ready;

	assign in_req = '{mode: mode, src: src_addr, dst: dst_addr, prev_hop: prev_hop,
		fwd_hop: fwd_hop, rid: route_id};

	rict_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready), .in_req(in_req),
		.q_valid(q_valid), .q_ready(q_ready), .q_req(q_req)
	);

	rict_back #(.TableDepth(TableDepth)) u_back (
		.clk(clk), .arst_n(arst_n), .q_valid(q_valid), .q_ready(q_ready), .q_req(q_req),
		.out_valid(out_valid), .out_ready(out_ready), .status(status), .slot(slot),
		.out_src(out_src), .out_dst(out_dst), .out_prev_hop(out_prev_hop),
		.out_fwd_hop(out_fwd_hop), .out_route_id(out_route_id)
	);
endmodule

// ===== rtl/core/rict_ram.sv =====
// Generic single-port-write, single-read RAM with registered read.
`timescale 1ns / 1ps
module rict_ram #(
	parameter int Width = 8,
	parameter int Depth = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

// ===== rtl/core/rict_front.sv =====
// Front end: accepts items, marks unused modes, queues requests for the back end.
`timescale 1ns / 1ps
module rict_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  rict_pkg::req_t     in_req,
	output logic               q_valid,
	input  logic               q_ready,
	output rict_pkg::req_t     q_req
);
	// two-entry queue
	rict_pkg::req_t buf_q [2];
	logic           wp_q, rp_q;
	logic [1:0]     cnt_q;
	rict_pkg::req_t req_c;

	always_comb begin
		req_c = in_req;
		// mode 3 behaves as a lookup that never matches
		if (!(in_req.mode inside {rict_pkg::MODE_BY_ID, rict_pkg::MODE_BY_DST,
			rict_pkg::MODE_INSERT})) begin
			req_c.mode = rict_pkg::MODE_UNUSED;
		end
	end

	assign in_ready = (cnt_q != 2'd2);
	assign q_valid = (cnt_q != 2'd0);
	assign q_req = buf_q[rp_q];

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			buf_q[wp_q] <= req_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (in_valid && in_ready) wp_q <= ~wp_q;
			if (q_valid && q_ready) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, in_valid && in_ready} - {1'b0, q_valid && q_ready};
		end
	end
endmodule

// ===== rtl/core/rict_back.sv =====
// Back end: sequential scan of the table in RAM, update or append, output register.
`timescale 1ns / 1ps
module rict_back #(
	parameter int TableDepth = rict_pkg::TableDepthDef
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     q_valid,
	output logic                     q_ready,
	input  rict_pkg::req_t           q_req,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [rict_pkg::StatW-1:0] status,
	output logic [rict_pkg::SlotW-1:0] slot,
	output logic [rict_pkg::AddrW-1:0] out_src,
	output logic [rict_pkg::AddrW-1:0] out_dst,
	output logic [rict_pkg::AddrW-1:0] out_prev_hop,
	output logic [rict_pkg::AddrW-1:0] out_fwd_hop,
	output logic [rict_pkg::RidW-1:0]  out_route_id
);
	localparam int IdxW = (TableDepth > 1) ? $clog2(TableDepth) : 1;
	localparam int CntW = $clog2(TableDepth + 1);
	localparam int AW = rict_pkg::AddrW;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SCAN = 2'd1;
	localparam logic [1:0] S_DONE = 2'd2;

	logic [1:0]           state_q;
	rict_pkg::req_t       req_q;
	logic [CntW-1:0]      fill_q;
	logic [CntW-1:0]      idx_q;     // slot whose data the RAM shows now
	logic                 rd_pend_q; // RAM output valid for idx_q
	logic [IdxW-1:0]      raddr;
	logic [rict_pkg::EntW-1:0] rdata, wdata;
	logic                 we;
	logic [IdxW-1:0]      waddr;
	logic                 match;
	logic [AW-1:0]        e_src, e_dst, e_ph, e_fh;
	logic [rict_pkg::RidW-1:0] e_rid;

	assign {e_src, e_dst, e_ph, e_fh, e_rid} = rdata;
	assign wdata = {req_q.src, req_q.dst, req_q.prev_hop, req_q.fwd_hop, req_q.rid};

	always_comb begin
		if (req_q.mode == rict_pkg::MODE_BY_DST) match = (e_src == req_q.src) && (e_dst == req_q.dst);
		else match = (e_src == req_q.src) && (e_rid == req_q.rid);
	end

	assign q_ready = (state_q == S_IDLE) && !out_valid;

	logic [CntW-1:0] nidx;
	assign nidx = idx_q + 1'b1;

	logic scan_end;
	assign scan_end = rd_pend_q && (match || nidx >= fill_q);
	// hold the matched slot on the read port so the done state still sees it
	assign raddr = (state_q == S_SCAN && !scan_end) ? nidx[IdxW-1:0] : idx_q[IdxW-1:0];
	// an insert into an empty table skips the scan and appends at slot 0
	assign we = (state_q == S_SCAN) && req_q.mode == rict_pkg::MODE_INSERT &&
		((rd_pend_q && (match || (nidx >= fill_q && fill_q < CntW'(TableDepth)))) ||
		(!rd_pend_q && fill_q == '0));
	assign waddr = (rd_pend_q && match) ? idx_q[IdxW-1:0] : fill_q[IdxW-1:0];

	rict_ram #(.Width(rict_pkg::EntW), .Depth(1 << IdxW)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
	);

	always_ff @(posedge clk) begin
		if (q_valid && q_ready) req_q <= q_req;
	end

	task automatic put(input logic [rict_pkg::StatW-1:0] st, input logic [CntW-1:0] k,
		input logic has);
		status <= st;
		slot <= has ? rict_pkg::SlotW'(k) : '0;
		out_src <= has ? req_q.src : '0;
		out_dst <= has ? req_q.dst : '0;
		out_prev_hop <= has ? req_q.prev_hop : '0;
		out_fwd_hop <= has ? req_q.fwd_hop : '0;
		out_route_id <= has ? req_q.rid : '0;
	endtask

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			fill_q <= '0;
			idx_q <= '0;
			rd_pend_q <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (out_valid && out_ready) out_valid <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (q_valid && q_ready) begin
						state_q <= S_SCAN;
						idx_q <= '1; // next read is slot 0
						rd_pend_q <= 1'b0;
					end
				end
				S_SCAN: begin
					if (req_q.mode == rict_pkg::MODE_UNUSED || fill_q == '0 && !rd_pend_q) begin
						state_q <= S_DONE;
						rd_pend_q <= 1'b0;
					end else if (!rd_pend_q) begin
						idx_q <= '0;
						rd_pend_q <= 1'b1;
					end else if (scan_end) begin
						state_q <= S_DONE;
						rd_pend_q <= match;
						if (!match) idx_q <= fill_q;
					end else begin
						idx_q <= nidx;
					end
				end
				default: begin
					// rd_pend_q here means "found a match at idx_q"
					out_valid <= 1'b1;
					state_q <= S_IDLE;
					if (req_q.mode == rict_pkg::MODE_INSERT) begin
						if (rd_pend_q) begin
							put(rict_pkg::ST_UPD, idx_q, 1'b1);
						end else if (fill_q < CntW'(TableDepth)) begin
							put(rict_pkg::ST_NEW, fill_q, 1'b1);
							fill_q <= fill_q + 1'b1;
						end else begin
							put(rict_pkg::ST_FULL, '0, 1'b0);
						end
					end else if (rd_pend_q && req_q.mode != rict_pkg::MODE_UNUSED) begin
						status <= rict_pkg::ST_HIT;
						slot <= rict_pkg::SlotW'(idx_q);
						out_src <= e_src;
						out_dst <= e_dst;
						out_prev_hop <= e_ph;
						out_fwd_hop <= e_fh;
						out_route_id <= e_rid;
					end else begin
						put(rict_pkg::ST_MISS, '0, 1'b0);
					end
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CntW'(TableDepth)) else $error("fill count beyond depth");
	a_fill_step: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q != $past(fill_q) |-> (fill_q == $past(fill_q) + 1'b1) && out_valid)
		else $error("fill count moved without an insert");
	a_no_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		q_ready |-> state_q == S_IDLE) else $error("request taken while busy");
`endif
endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for the route id table: random and directed lookups and inserts.
`timescale 1ns / 1ps
module testbench;
	localparam int Depth = rict_pkg::TableDepthDef;

	typedef struct packed {
		logic [rict_pkg::StatW-1:0] st;
		logic [rict_pkg::SlotW-1:0] sl;
		logic [rict_pkg::AddrW-1:0] src;
		logic [rict_pkg::AddrW-1:0] dst;
		logic [rict_pkg::AddrW-1:0] ph;
		logic [rict_pkg::AddrW-1:0] fh;
		logic [rict_pkg::RidW-1:0] rid;
	} resp_t;

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [rict_pkg::ModeW-1:0] mode = '0;
	logic [rict_pkg::AddrW-1:0] src_addr = '0, dst_addr = '0, prev_hop = '0, fwd_hop = '0;
	logic [rict_pkg::RidW-1:0] route_id = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [rict_pkg::StatW-1:0] status;
	logic [rict_pkg::SlotW-1:0] slot;
	logic [rict_pkg::AddrW-1:0] out_src, out_dst, out_prev_hop, out_fwd_hop;
	logic [rict_pkg::RidW-1:0] out_route_id;

	route_id_cache_table_unit dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// shadow table
	int unsigned fill;
	logic [rict_pkg::AddrW-1:0] t_src [Depth];
	logic [rict_pkg::AddrW-1:0] t_dst [Depth];
	logic [rict_pkg::AddrW-1:0] t_ph [Depth];
	logic [rict_pkg::AddrW-1:0] t_fh [Depth];
	logic [rict_pkg::RidW-1:0] t_rid [Depth];

	rict_pkg::req_t pending_items[$];
	resp_t expected_resps[$];
	int errors = 0;
	int n_sent = 0, n_recv = 0, n_full = 0, n_upd = 0, n_hit = 0;
	bit drain_hold = 0;

	function automatic resp_t route_predict(rict_pkg::req_t r);
		resp_t o;
		int k;
		o = '0;
		k = -1;
		if (r.mode != rict_pkg::MODE_UNUSED) begin
			for (int i = 0; i < fill; i++) begin
				if (k < 0 && t_src[i] == r.src &&
						(r.mode == rict_pkg::MODE_BY_DST ? t_dst[i] == r.dst : t_rid[i] == r.rid))
					k = i;
			end
		end
		if (r.mode == rict_pkg::MODE_INSERT) begin
			if (k >= 0) o.st = rict_pkg::ST_UPD;
			else if (fill < Depth) begin
				k = fill;
				fill++;
				o.st = rict_pkg::ST_NEW;
			end else begin
				o.st = rict_pkg::ST_FULL;
				return o;
			end
			t_src[k] = r.src;
			t_dst[k] = r.dst;
			t_ph[k] = r.prev_hop;
			t_fh[k] = r.fwd_hop;
			t_rid[k] = r.rid;
		end else begin
			if (r.mode == rict_pkg::MODE_UNUSED) k = -1;
			o.st = k >= 0 ? rict_pkg::ST_HIT : rict_pkg::ST_MISS;
		end
		if (k >= 0) begin
			o.sl = k[rict_pkg::SlotW-1:0];
			o.src = t_src[k];
			o.dst = t_dst[k];
			o.ph = t_ph[k];
			o.fh = t_fh[k];
			o.rid = t_rid[k];
		end
		return o;
	endfunction

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		$display("mismatch %s: got %0h want %0h (result %0d)", what, got, want, n_recv);
		errors++;
	endtask

	task automatic add_item(rict_pkg::req_t r);
		pending_items = {pending_items, r};
	endtask

	function automatic int pick_gap();
		return ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
	endfunction

	// driver
	int in_gap = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				expected_resps = {expected_resps, route_predict(pending_items.pop_front())};
				n_sent++;
			end
			if ((!in_valid || in_ready)) begin
				if (in_gap > 0) begin
					in_gap <= in_gap - 1;
					in_valid <= 1'b0;
				end else if (pending_items.size() > 0 &&
						!(drain_hold && expected_resps.size() != 0)) begin
					in_valid <= 1'b1;
					mode <= pending_items[0].mode;
					src_addr <= pending_items[0].src;
					dst_addr <= pending_items[0].dst;
					prev_hop <= pending_items[0].prev_hop;
					fwd_hop <= pending_items[0].fwd_hop;
					route_id <= pending_items[0].rid;
					if ($urandom_range(0, 3) == 0) in_gap <= pick_gap();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	int out_gap = 0;
	always @(posedge clk) begin
		resp_t e;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				n_recv++;
				if (expected_resps.size() == 0) begin
					report_mismatch("unexpected result status", 64'(status), 64'(0));
				end else begin
					e = expected_resps.pop_front();
					if (status != e.st) report_mismatch("status", 64'(status), 64'(e.st));
					if (slot != e.sl) report_mismatch("slot", 64'(slot), 64'(e.sl));
					if (out_src != e.src) report_mismatch("out_src", 64'(out_src), 64'(e.src));
					if (out_dst != e.dst) report_mismatch("out_dst", 64'(out_dst), 64'(e.dst));
					if (out_prev_hop != e.ph)
						report_mismatch("out_prev_hop", 64'(out_prev_hop), 64'(e.ph));
					if (out_fwd_hop != e.fh)
						report_mismatch("out_fwd_hop", 64'(out_fwd_hop), 64'(e.fh));
					if (out_route_id != e.rid)
						report_mismatch("out_route_id", 64'(out_route_id), 64'(e.rid));
					if (e.st == rict_pkg::ST_FULL) n_full++;
					if (e.st == rict_pkg::ST_UPD) n_upd++;
					if (e.st == rict_pkg::ST_HIT) n_hit++;
				end
			end
			if (out_gap > 0) begin
				out_gap <= out_gap - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
				if ($urandom_range(0, 3) == 0) out_gap <= pick_gap();
			end
		end
	end

	// small pools so keys collide often
	logic [rict_pkg::AddrW-1:0] src_pool [8];
	logic [rict_pkg::AddrW-1:0] dst_pool [8];
	logic [rict_pkg::RidW-1:0] rid_pool [8];

	function automatic logic [rict_pkg::AddrW-1:0] rnd_addr();
		logic [63:0] w;
		w = {$urandom(), $urandom()};
		return w[rict_pkg::AddrW-1:0];
	endfunction

	function automatic rict_pkg::req_t make_item(logic [rict_pkg::ModeW-1:0] m, bit pooled);
		rict_pkg::req_t r;
		r.mode = m;
		r.prev_hop = rnd_addr();
		r.fwd_hop = rnd_addr();
		if (pooled) begin
			r.src = src_pool[$urandom_range(0, 7)];
			r.dst = dst_pool[$urandom_range(0, 7)];
			r.rid = rid_pool[$urandom_range(0, 7)];
		end else begin
			r.src = rnd_addr();
			r.dst = rnd_addr();
			r.rid = $urandom();
		end
		return r;
	endfunction

	function automatic rict_pkg::req_t fixed_item(logic [rict_pkg::ModeW-1:0] m,
			logic [rict_pkg::AddrW-1:0] s, logic [rict_pkg::AddrW-1:0] d,
			logic [rict_pkg::RidW-1:0] id);
		rict_pkg::req_t r;
		r.mode = m;
		r.src = s;
		r.dst = d;
		r.rid = id;
		r.prev_hop = ~s;
		r.fwd_hop = d ^ 48'h5a5a_5a5a_5a5a;
		return r;
	endfunction

	task automatic wait_drained();
		while (pending_items.size() != 0 || in_valid || expected_resps.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		logic [rict_pkg::ModeW-1:0] m;
		fill = 0;
		arst_n = 1'b1;
		#1 arst_n = 1'b0;
		for (int i = 0; i < 8; i++) begin
			src_pool[i] = rnd_addr();
			dst_pool[i] = rnd_addr();
			rid_pool[i] = $urandom();
		end
		src_pool[0] = '0;
		src_pool[1] = '1;
		rid_pool[0] = '0;
		rid_pool[1] = '1;
		dst_pool[0] = '0;
		dst_pool[1] = '1;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		// directed: empty table, extremes, update, duplicates, unused mode
		add_item(fixed_item(rict_pkg::MODE_BY_ID, '0, '0, '0));
		add_item(fixed_item(rict_pkg::MODE_BY_DST, '1, '1, '1));
		add_item(fixed_item(rict_pkg::MODE_INSERT, '0, '0, '0));
		add_item(fixed_item(rict_pkg::MODE_INSERT, '1, '1, '1));
		add_item(fixed_item(rict_pkg::MODE_BY_ID, '0, '1, '0));
		add_item(fixed_item(rict_pkg::MODE_BY_DST, '1, '1, '0));
		add_item(fixed_item(rict_pkg::MODE_INSERT, '0, 48'h1234, '0));
		add_item(fixed_item(rict_pkg::MODE_BY_DST, '0, 48'h1234, '1));
		add_item(fixed_item(rict_pkg::MODE_INSERT, '1, '1, 32'h0));
		add_item(fixed_item(rict_pkg::MODE_BY_DST, '1, '1, '0));
		add_item(fixed_item(rict_pkg::MODE_UNUSED, '0, '0, '0));
		add_item(fixed_item(rict_pkg::MODE_BY_ID, '1, '0, 32'h0));
		wait_drained();
		drain_hold = 1;
		for (int n = 0; n < 600; n++) begin
			if (n == 300) begin
				// fill the table, then overflow and update while full
				wait_drained();
				while (fill + pending_items.size() < Depth + 4)
					add_item(make_item(rict_pkg::MODE_INSERT, 0));
				add_item(make_item(rict_pkg::MODE_INSERT, 1));
				add_item(make_item(rict_pkg::MODE_INSERT, 0));
			end
			if (n == 100) drain_hold = 0;
			case ($urandom_range(0, 9))
				0, 1, 2: m = rict_pkg::MODE_INSERT;
				3, 4, 5: m = rict_pkg::MODE_BY_ID;
				6, 7, 8: m = rict_pkg::MODE_BY_DST;
				default: m = rict_pkg::MODE_UNUSED;
			endcase
			add_item(make_item(m, $urandom_range(0, 4) != 0));
			if (n % 20 == 0) wait_drained();
		end
		wait_drained();
		repeat (Depth + 20) @(posedge clk);
		$display("sent %0d items, got %0d results: %0d hits, %0d updates, %0d refused",
			n_sent, n_recv, n_hit, n_upd, n_full);
		$display("table reached %0d of %0d entries", fill, Depth);
		if (errors == 0 && expected_resps.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

	initial begin
		#10ms;
		$display("status: fail");
		$finish;
	end
endmodule

// ===== filelist.f =====
rtl/core/rict_pkg.sv
rtl/core/rict_ram.sv
rtl/core/rict_front.sv
rtl/core/rict_back.sv
rtl/core/route_id_cache_table_unit.sv
verif/testbench.sv
